FILE: src/bgsc_pkg.sv
// Package for the GF(32) BCH symbol checksum unit.
// Holds field widths, the tail length, register indexes and generator reset values.
// No dependencies.
`default_nettype none

package bgsc_pkg;

  localparam int SYM_W        = 5;
  localparam int WORD_W       = 30;
  localparam int TAIL_SYMBOLS = 6;
  localparam int FILL_W       = 3;
  localparam int GEN_COUNT    = 5;
  localparam int CFG_IDX_W    = 3;

  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [FILL_W-1:0] fill_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEN_WORD_0 = 3'd0,
    REG_GEN_WORD_1 = 3'd1,
    REG_GEN_WORD_2 = 3'd2,
    REG_GEN_WORD_3 = 3'd3,
    REG_GEN_WORD_4 = 3'd4
  } cfg_reg_t;

  localparam word_t GEN_RESET [GEN_COUNT] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  typedef struct packed {
    word_t checksum;
    logic  short_message;
  } result_t;

endpackage

`default_nettype wire

FILE: src/bch_gf32_symbol_checksum_unit.sv
// Top level of the GF(32) BCH symbol checksum unit: polymod fold, tail packing, output skid.
// Depends on bgsc_pkg.
//
// channel  | dir | tdata bits                  | tuser            | tlast
// s_axis   | in  | [4:0] symbol, [7:5] zero    | -                | last
// m_axis   | out | [29:0] checksum, [31:30] 0  | [0] short_message| -
// cfg      | in  | cfg_data [29:0] to register cfg_index (0..4), on cfg_we
//
// One symbol per cycle while s_axis_tready is high; the fold and tail packing sit between the
// message state registers and the result register, so each result is registered from its last symbol.
// A two-entry output buffer (result register plus skid) lets input continue while a
// result waits; s_axis_tready drops only while both entries are full.
// rst is synchronous and restores generator words and clears message state.
`default_nettype none

module bch_gf32_symbol_checksum_unit
  import bgsc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [4:0] symbol
  input  wire logic                 s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [31:0]               m_axis_tdata,   // [29:0] checksum
  output logic [0:0]                m_axis_tuser,   // [0] short_message
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  word_t   gen_words [GEN_COUNT];
  word_t   remainder, remainder_next;
  word_t   tail_symbols, tail_next;
  fill_t   tail_fill, fill_next;
  word_t   packed_tail;
  result_t result_next;
  result_t out_reg, skid_reg;
  logic    out_valid, skid_valid;
  logic    in_xfer, emit;
  sym_t    sym, feedback;

  assign sym     = s_axis_tdata[SYM_W-1:0];
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign emit    = in_xfer && s_axis_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GEN_COUNT; i++) gen_words[i] <= GEN_RESET[i];
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GEN_WORD_0: gen_words[0] <= cfg_data;
        REG_GEN_WORD_1: gen_words[1] <= cfg_data;
        REG_GEN_WORD_2: gen_words[2] <= cfg_data;
        REG_GEN_WORD_3: gen_words[3] <= cfg_data;
        REG_GEN_WORD_4: gen_words[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    feedback       = remainder[WORD_W-1 -: SYM_W] ^ tail_symbols[WORD_W-1 -: SYM_W];
    remainder_next = remainder;
    fill_next      = tail_fill;
    if (tail_fill == FILL_W'(TAIL_SYMBOLS)) begin
      remainder_next = {remainder[WORD_W-SYM_W-1:0], {SYM_W{1'b0}}};
      for (int i = 0; i < GEN_COUNT; i++) begin
        if (feedback[i]) remainder_next = remainder_next ^ gen_words[i];
      end
    end else begin
      fill_next = tail_fill + 1'b1;
    end
    tail_next   = {tail_symbols[WORD_W-SYM_W-1:0], sym};
    packed_tail = '0;
    for (int k = 1; k <= TAIL_SYMBOLS; k++) begin
      if (fill_next == FILL_W'(k)) packed_tail = tail_next << (SYM_W * (TAIL_SYMBOLS - k));
    end
    result_next.checksum      = remainder_next ^ packed_tail;
    result_next.short_message = (fill_next != FILL_W'(TAIL_SYMBOLS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder    <= '0;
      tail_symbols <= '0;
      tail_fill    <= '0;
    end else if (in_xfer) begin
      if (s_axis_tlast) begin
        remainder    <= '0;
        tail_symbols <= '0;
        tail_fill    <= '0;
      end else begin
        remainder    <= remainder_next;
        tail_symbols <= tail_next;
        tail_fill    <= fill_next;
      end
    end
  end

  assign s_axis_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_axis_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= emit;
        end
      end else if (emit) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) out_reg <= skid_reg;
      else if (emit)  out_reg <= result_next;
    end else if (emit) begin
      skid_reg <= result_next;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = {2'b00, out_reg.checksum};
  assign m_axis_tuser[0] = out_reg.short_message;

endmodule

`default_nettype wire

FILE: sim/bch_gf32_symbol_checksum_unit_tb.sv
// Testbench for bch_gf32_symbol_checksum_unit: streams 5-bit symbol messages and
// checks each checksum and short flag against a polymod predictor kept in the bench.
// Depends on bgsc_pkg and the unit RTL.
module bch_gf32_symbol_checksum_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bgsc_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int PH_ZERO         = 1;
  localparam int PH_ONES         = 2;
  localparam int PH_ONEHOT       = 3;
  localparam int PH_STRAY        = 5;
  localparam int SETTLE_CYCLES   = 4;

  typedef struct {
    sym_t symbol;
    logic last;
  } symbol_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;    // [4:0] symbol, [7:5] zero
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;         // [29:0] checksum, [31:30] zero
  logic [0:0]           m_axis_tuser;         // [0] short_message
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;

  symbol_item_t pending_symbols[$];
  result_t      sums_due[$];
  symbol_item_t cur_symbol;
  bit           sym_busy = 1'b0;
  bit           calm = 1'b0;
  int           in_gap = 0;
  int           out_stall = 0;
  int           errors = 0;
  int           cycle_count = 0;
  int           symbols_sent = 0;
  int           items_queued = 0;
  int           sums_checked = 0;
  int           shorts_checked = 0;
  int           settings_used = 1;

  word_t gen_word [GEN_COUNT];
  word_t poly_rem;
  word_t tail_word;
  fill_t tail_count;

  bch_gf32_symbol_checksum_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t poly_fold(word_t r_in, sym_t s);
    logic [SYM_W-1:0] fb;
    word_t            r;
    fb = r_in[WORD_W-1 -: SYM_W] ^ s;
    r  = {r_in[WORD_W-SYM_W-1:0], {SYM_W{1'b0}}};
    for (int i = 0; i < GEN_COUNT; i++) begin
      if (fb[i]) r ^= gen_word[i];
    end
    return r;
  endfunction

  task automatic absorb_symbol(sym_t s, logic lst);
    word_t   aligned;
    result_t sum;
    if (tail_count >= TAIL_SYMBOLS) begin
      poly_rem  = poly_fold(poly_rem, tail_word[WORD_W-1 -: SYM_W]);
      tail_word = {tail_word[WORD_W-SYM_W-1:0], s};
    end else begin
      tail_word  = {tail_word[WORD_W-SYM_W-1:0], s};
      tail_count = tail_count + 1'b1;
    end
    if (lst) begin
      aligned           = tail_word << (SYM_W * (TAIL_SYMBOLS - tail_count));
      sum.checksum      = poly_rem ^ aligned;
      sum.short_message = (tail_count < TAIL_SYMBOLS);
      sums_due.push_back(sum);
      poly_rem   = '0;
      tail_word  = '0;
      tail_count = '0;
    end
  endtask

  // input side: hold each transfer until accepted, idle in random bursts
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      sym_busy = 1'b0;
      in_gap   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_symbol(cur_symbol.symbol, cur_symbol.last);
        symbols_sent++;
        sym_busy = 1'b0;
      end
      if (!sym_busy) begin
        if (in_gap == 0 && !calm && $urandom_range(0, 15) == 0) in_gap = $urandom_range(1, 8);
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_symbols.size() > 0) begin
          cur_symbol = pending_symbols.pop_front();
          sym_busy   = 1'b1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(8-SYM_W){1'b0}}, cur_symbol.symbol};
          s_axis_tlast  <= cur_symbol.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: check each transfer, stall in random bursts
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sums_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected checksum %h short %b", $time,
                   m_axis_tdata[WORD_W-1:0], m_axis_tuser[0]);
        end else begin
          want = sums_due.pop_front();
          if (m_axis_tdata[WORD_W-1:0] !== want.checksum) begin
            errors++;
            $display("%0t: checksum expected %h got %h", $time, want.checksum,
                     m_axis_tdata[WORD_W-1:0]);
          end
          if (m_axis_tuser[0] !== want.short_message) begin
            errors++;
            $display("%0t: short_message expected %b got %b", $time, want.short_message,
                     m_axis_tuser[0]);
          end
        end
        sums_checked++;
        if (m_axis_tuser[0]) shorts_checked++;
      end
      if (out_stall == 0 && !calm && $urandom_range(0, 3) == 0) out_stall = $urandom_range(1, 8);
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d checksums outstanding", cycle_count,
               sums_due.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_gen(logic [CFG_IDX_W-1:0] idx, word_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx < GEN_COUNT) gen_word[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_generators(int phase);
    word_t w;
    for (int i = 0; i < GEN_COUNT; i++) begin
      case (phase)
        PH_ZERO:   w = '0;
        PH_ONES:   w = '1;
        PH_ONEHOT: w = word_t'(1) << $urandom_range(0, WORD_W-1);
        PHASES-1:  w = GEN_RESET[i];
        default:   w = word_t'($urandom);
      endcase
      write_gen(cfg_reg_t'(i), w);
    end
    // indexes past the last generator must be dropped
    if (phase == PH_STRAY) begin
      for (int k = GEN_COUNT; k < (1 << CFG_IDX_W); k++) write_gen(CFG_IDX_W'(k), word_t'($urandom));
    end
    settings_used++;
  endtask

  task automatic push_symbol(sym_t s, logic lst);
    symbol_item_t it;
    it.symbol = s;
    it.last   = lst;
    pending_symbols.push_back(it);
    items_queued++;
  endtask

  task automatic queue_message(int len);
    sym_t s;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0:       s = '0;
        1:       s = '1;
        default: s = sym_t'($urandom);
      endcase
      push_symbol(s, k == len - 1);
    end
  endtask

  task automatic drain_unit();
    while (pending_symbols.size() != 0 || sym_busy || sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int target;
    gen_word   = GEN_RESET;
    poly_rem   = '0;
    tail_word  = '0;
    tail_count = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) calm = 1'b1;
      if (phase > 0) begin
        drain_unit();
        load_generators(phase);
      end else begin
        push_symbol('1, 1'b1);
        push_symbol('0, 1'b1);
        for (int k = 0; k < TAIL_SYMBOLS - 1; k++) push_symbol(k[0] ? '1 : '0, k == TAIL_SYMBOLS - 2);
        for (int k = 0; k < TAIL_SYMBOLS; k++) push_symbol('1, k == TAIL_SYMBOLS - 1);
        for (int k = 0; k <= TAIL_SYMBOLS; k++) push_symbol(k == 0 ? '1 : '0, k == TAIL_SYMBOLS);
      end
      target = items_queued + ITEMS_PER_PHASE;
      while (items_queued < target) begin
        queue_message(($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12));
      end
    end
    drain_unit();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d checksums (%0d short) over %0d symbols", sums_checked,
             shorts_checked, symbols_sent);
    $display("under %0d generator settings with random input gaps and output stalls",
             settings_used);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/bgsc_pkg.sv
src/bch_gf32_symbol_checksum_unit.sv
sim/bch_gf32_symbol_checksum_unit_tb.sv
